// ----- src/pdc_pkg.sv -----
`timescale 1ns / 1ps

package pdc_pkg;

   localparam int GAIN_WIDTH      = 32;
   localparam int LIMIT_WIDTH     = 15;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   // saturated gain * difference term and the wide sums built from it
   localparam int TERM_WIDTH   = 63;
   localparam int SUM_WIDTH    = 64;
   localparam int TERM_SAT_BIT = 61;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOOP_MODE      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_P         = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_I         = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_D         = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INTEGRAL_LIMIT = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUTPUT_LIMIT   = 3'd5;

   localparam logic MODE_POSITIONAL  = 1'b0;
   localparam logic MODE_INCREMENTAL = 1'b1;

   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 15'd16384;

   typedef struct packed {
      logic                   loop_mode;
      logic [GAIN_WIDTH-1:0]  gain_p;
      logic [GAIN_WIDTH-1:0]  gain_i;
      logic [GAIN_WIDTH-1:0]  gain_d;
      logic [LIMIT_WIDTH-1:0] integral_limit;
      logic [LIMIT_WIDTH-1:0] output_limit;
   } cfg_type;

endpackage

// ----- src/pdc_csr.sv -----
`timescale 1ns / 1ps

module pdc_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [pdc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [pdc_pkg::CSR_DATA_WIDTH-1:0]    csr_wr_data,
   output pdc_pkg::cfg_type                      cfg
);
   import pdc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LOOP_MODE:      cfg_in.loop_mode      = csr_wr_data[0];
            CSR_GAIN_P:         cfg_in.gain_p         = csr_wr_data[GAIN_WIDTH-1:0];
            CSR_GAIN_I:         cfg_in.gain_i         = csr_wr_data[GAIN_WIDTH-1:0];
            CSR_GAIN_D:         cfg_in.gain_d         = csr_wr_data[GAIN_WIDTH-1:0];
            CSR_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_wr_data[LIMIT_WIDTH-1:0];
            CSR_OUTPUT_LIMIT:   cfg_in.output_limit   = csr_wr_data[LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.loop_mode      <= MODE_POSITIONAL;
         cfg_ff.gain_p         <= '0;
         cfg_ff.gain_i         <= '0;
         cfg_ff.gain_d         <= '0;
         cfg_ff.integral_limit <= LIMIT_RESET;
         cfg_ff.output_limit   <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/pdc_error.sv -----
`timescale 1ns / 1ps

module pdc_error #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         loop_mode,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_measured,
   input  logic signed [DATA_WIDTH-1:0] req_target,
   output logic                         opnd_valid,
   input  logic                         opnd_stall,
   output logic signed [DATA_WIDTH+2:0] opnd_p,
   output logic signed [DATA_WIDTH+2:0] opnd_i,
   output logic signed [DATA_WIDTH+2:0] opnd_d
);
   import pdc_pkg::*;

   localparam int EW  = DATA_WIDTH + 1;
   localparam int OPW = DATA_WIDTH + 3;

   logic                  valid_ff, valid_in;
   logic                  hold, take;
   logic signed [EW-1:0]  e_now_ff, e_now_in;
   logic signed [EW-1:0]  e_prev_ff, e_prev_in;
   logic signed [EW-1:0]  e_prev2_ff, e_prev2_in;
   logic signed [OPW-1:0] opnd_p_ff, opnd_p_in;
   logic signed [OPW-1:0] opnd_i_ff, opnd_i_in;
   logic signed [OPW-1:0] opnd_d_ff, opnd_d_in;
   logic signed [EW-1:0]  error_new;
   logic signed [OPW-1:0] diff1, diff2;

   assign hold      = valid_ff & opnd_stall;
   assign take      = req_valid & ~hold;
   assign req_stall = hold;
   assign valid_in  = take | hold;

   always_comb begin
      error_new = EW'(req_target) - EW'(req_measured);
      // first and second difference against the kept history
      diff1 = OPW'(error_new) - OPW'(e_now_ff);
      diff2 = diff1 - OPW'(e_now_ff) + OPW'(e_prev_ff);

      e_now_in   = e_now_ff;
      e_prev_in  = e_prev_ff;
      e_prev2_in = e_prev2_ff;
      opnd_p_in  = opnd_p_ff;
      opnd_i_in  = opnd_i_ff;
      opnd_d_in  = opnd_d_ff;
      if (take) begin
         e_prev2_in = e_prev_ff;
         e_prev_in  = e_now_ff;
         e_now_in   = error_new;
         opnd_i_in  = OPW'(error_new);
         if (loop_mode == MODE_INCREMENTAL) begin
            opnd_p_in = diff1;
            opnd_d_in = diff2;
         end else begin
            opnd_p_in = OPW'(error_new);
            opnd_d_in = diff1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         e_now_ff   <= '0;
         e_prev_ff  <= '0;
         e_prev2_ff <= '0;
      end else begin
         valid_ff   <= valid_in;
         e_now_ff   <= e_now_in;
         e_prev_ff  <= e_prev_in;
         e_prev2_ff <= e_prev2_in;
      end
   end

   always_ff @(posedge clock) begin
      opnd_p_ff <= opnd_p_in;
      opnd_i_ff <= opnd_i_in;
      opnd_d_ff <= opnd_d_in;
   end

   assign opnd_valid = valid_ff;
   assign opnd_p     = opnd_p_ff;
   assign opnd_i     = opnd_i_ff;
   assign opnd_d     = opnd_d_ff;

endmodule

// ----- src/pdc_term.sv -----
`timescale 1ns / 1ps

module pdc_term #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  pdc_pkg::cfg_type                        cfg,
   input  logic                                    opnd_valid,
   output logic                                    opnd_stall,
   input  logic signed [DATA_WIDTH+2:0]            opnd_p,
   input  logic signed [DATA_WIDTH+2:0]            opnd_i,
   input  logic signed [DATA_WIDTH+2:0]            opnd_d,
   output logic                                    sum_valid,
   input  logic                                    sum_stall,
   output logic signed [pdc_pkg::SUM_WIDTH-1:0]    sum,
   output logic signed [pdc_pkg::TERM_WIDTH-1:0]   iterm
);
   import pdc_pkg::*;

   localparam int OPW = DATA_WIDTH + 3;
   localparam int PW  = GAIN_WIDTH + 1 + OPW;
   localparam int CW  = (PW > SUM_WIDTH) ? PW : SUM_WIDTH;
   localparam logic signed [CW-1:0] SAT_POS = CW'(1) <<< TERM_SAT_BIT;
   localparam logic signed [CW-1:0] SAT_NEG = -SAT_POS;

   logic                         valid2_ff, valid2_in;
   logic                         valid3_ff, valid3_in;
   logic                         hold2, hold3, take2, take3;
   logic signed [PW-1:0]         prod_p_ff, prod_p_in;
   logic signed [PW-1:0]         prod_i_ff, prod_i_in;
   logic signed [PW-1:0]         prod_d_ff, prod_d_in;
   logic signed [SUM_WIDTH-1:0]  sum_ff, sum_in;
   logic signed [TERM_WIDTH-1:0] iterm_ff, iterm_in;
   logic signed [TERM_WIDTH-1:0] term_p, term_i, term_d;
   logic signed [SUM_WIDTH-1:0]  i_add;

   function automatic logic signed [TERM_WIDTH-1:0] sat_term(
      input logic signed [PW-1:0] prod
   );
      logic signed [CW-1:0]         wide;
      logic signed [TERM_WIDTH-1:0] res;
      wide = CW'(prod);
      if (wide > SAT_POS) begin
         res = TERM_WIDTH'(SAT_POS);
      end else if (wide < SAT_NEG) begin
         res = TERM_WIDTH'(SAT_NEG);
      end else begin
         res = TERM_WIDTH'(wide);
      end
      return res;
   endfunction

   assign hold3      = valid3_ff & sum_stall;
   assign take3      = valid2_ff & ~hold3;
   assign hold2      = valid2_ff & hold3;
   assign take2      = opnd_valid & ~hold2;
   assign opnd_stall = hold2;
   assign valid2_in  = take2 | hold2;
   assign valid3_in  = take3 | hold3;

   // product stage
   always_comb begin
      prod_p_in = prod_p_ff;
      prod_i_in = prod_i_ff;
      prod_d_in = prod_d_ff;
      if (take2) begin
         prod_p_in = PW'($signed({1'b0, cfg.gain_p})) * PW'(opnd_p);
         prod_i_in = PW'($signed({1'b0, cfg.gain_i})) * PW'(opnd_i);
         prod_d_in = PW'($signed({1'b0, cfg.gain_d})) * PW'(opnd_d);
      end
   end

   // saturate and sum stage
   always_comb begin
      term_p = sat_term(prod_p_ff);
      term_i = sat_term(prod_i_ff);
      term_d = sat_term(prod_d_ff);
      // positional mode adds the integral later, after accumulation
      i_add  = (cfg.loop_mode == MODE_INCREMENTAL) ? SUM_WIDTH'(term_i) : '0;
      sum_in   = sum_ff;
      iterm_in = iterm_ff;
      if (take3) begin
         sum_in   = SUM_WIDTH'(term_p) + SUM_WIDTH'(term_d) + i_add;
         iterm_in = term_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid2_ff <= valid2_in;
         valid3_ff <= valid3_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_p_ff <= prod_p_in;
      prod_i_ff <= prod_i_in;
      prod_d_ff <= prod_d_in;
      sum_ff    <= sum_in;
      iterm_ff  <= iterm_in;
   end

   assign sum_valid = valid3_ff;
   assign sum       = sum_ff;
   assign iterm     = iterm_ff;

endmodule

// ----- src/pdc_accum.sv -----
`timescale 1ns / 1ps

module pdc_accum #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  pdc_pkg::cfg_type                        cfg,
   input  logic                                    sum_valid,
   output logic                                    sum_stall,
   input  logic signed [pdc_pkg::SUM_WIDTH-1:0]    sum,
   input  logic signed [pdc_pkg::TERM_WIDTH-1:0]   iterm,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [DATA_WIDTH-1:0]            rsp_drive
);
   import pdc_pkg::*;

   localparam int AW = 32 + FRAC_BITS;
   localparam int OW = LIMIT_WIDTH + 1 + FRAC_BITS;
   localparam int XW = (DATA_WIDTH > LIMIT_WIDTH) ? DATA_WIDTH : LIMIT_WIDTH;
   localparam logic signed [SUM_WIDTH-1:0] IACC_MAX =
      (SUM_WIDTH'(1) <<< (AW - 1)) - SUM_WIDTH'(1);
   localparam logic [XW-1:0] DRIVE_MAX = XW'({(DATA_WIDTH-1){1'b1}});

   logic                        valid4_ff, valid4_in;
   logic                        valid5_ff, valid5_in;
   logic                        valid6_ff, valid6_in;
   logic                        hold4, hold5, hold6, take4, take5, take6;
   logic                        incremental;
   logic signed [AW-1:0]        iacc_ff, iacc_in;
   logic signed [OW-1:0]        oacc_ff, oacc_in;
   logic signed [SUM_WIDTH-1:0] s4_sum_ff, s4_sum_in;
   logic signed [OW-1:0]        val5_ff, val5_in;
   logic signed [DATA_WIDTH-1:0] drive_ff, drive_in;
   logic signed [SUM_WIDTH-1:0] ilim, olim;
   logic signed [SUM_WIDTH-1:0] iacc_next, out_next, pos_val;
   logic                        neg6;
   logic signed [OW-1:0]        mag6;
   logic [LIMIT_WIDTH-1:0]      whole6;
   logic [XW-1:0]               whole_x, clip6;

   function automatic logic signed [SUM_WIDTH-1:0] clamp_sym(
      input logic signed [SUM_WIDTH-1:0] v,
      input logic signed [SUM_WIDTH-1:0] lim
   );
      logic signed [SUM_WIDTH-1:0] res;
      if (v > lim) begin
         res = lim;
      end else if (v < -lim) begin
         res = -lim;
      end else begin
         res = v;
      end
      return res;
   endfunction

   assign hold6     = valid6_ff & rsp_stall;
   assign take6     = valid5_ff & ~hold6;
   assign hold5     = valid5_ff & hold6;
   assign take5     = valid4_ff & ~hold5;
   assign hold4     = valid4_ff & hold5;
   assign take4     = sum_valid & ~hold4;
   assign sum_stall = hold4;
   assign valid4_in = take4 | hold4;
   assign valid5_in = take5 | hold5;
   assign valid6_in = take6 | hold6;

   assign incremental = (cfg.loop_mode == MODE_INCREMENTAL);
   assign ilim = SUM_WIDTH'({cfg.integral_limit, {FRAC_BITS{1'b0}}});
   assign olim = SUM_WIDTH'({cfg.output_limit, {FRAC_BITS{1'b0}}});

   // accumulate stage: integral in positional mode, output in incremental mode
   always_comb begin
      if (incremental) begin
         iacc_next = clamp_sym(SUM_WIDTH'(iterm), IACC_MAX);
      end else begin
         iacc_next = clamp_sym(SUM_WIDTH'(iacc_ff) + SUM_WIDTH'(iterm), ilim);
      end
      out_next = clamp_sym(SUM_WIDTH'(oacc_ff) + sum, olim);
      iacc_in   = take4 ? AW'(iacc_next) : iacc_ff;
      s4_sum_in = s4_sum_ff;
      if (take4) begin
         s4_sum_in = incremental ? out_next : sum;
      end
   end

   // positional output: add the integral that this item left behind
   always_comb begin
      pos_val = clamp_sym(s4_sum_ff + SUM_WIDTH'(iacc_ff), olim);
      val5_in = val5_ff;
      if (take5) begin
         val5_in = incremental ? OW'(s4_sum_ff) : OW'(pos_val);
      end
   end

   // user must hold mode with items in flight (unenforced); one write site live
   always_comb begin
      oacc_in = oacc_ff;
      priority if (take4 && incremental) begin
         oacc_in = OW'(out_next);
      end else if (take5 && !incremental) begin
         oacc_in = OW'(pos_val);
      end
   end

   // output stage: truncate toward zero, then fit the drive width
   always_comb begin
      neg6    = val5_ff[OW-1];
      mag6    = neg6 ? -val5_ff : val5_ff;
      whole6  = mag6[OW-2:FRAC_BITS];
      whole_x = XW'(whole6);
      clip6   = (whole_x > DRIVE_MAX) ? DRIVE_MAX : whole_x;
      drive_in = drive_ff;
      if (take6) begin
         drive_in = neg6 ? -DATA_WIDTH'(clip6) : DATA_WIDTH'(clip6);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
         valid6_ff <= 1'b0;
         iacc_ff   <= '0;
         oacc_ff   <= '0;
      end else begin
         valid4_ff <= valid4_in;
         valid5_ff <= valid5_in;
         valid6_ff <= valid6_in;
         iacc_ff   <= iacc_in;
         oacc_ff   <= oacc_in;
      end
   end

   always_ff @(posedge clock) begin
      s4_sum_ff <= s4_sum_in;
      val5_ff   <= val5_in;
      drive_ff  <= drive_in;
   end

   assign rsp_valid = valid6_ff;
   assign rsp_drive = drive_ff;

endmodule

// ----- src/pid_position_delta_controller_top.sv -----
`timescale 1ns / 1ps
// PID controller, positional or incremental, fixed point.
//
// Input channel (req_valid / req_stall): one measured value and one target
// per transfer. Result channel (rsp_valid / rsp_stall): one drive value per
// input transfer, in order. Both channels move a transfer on a clock edge
// where valid is high and stall is low.
// Configuration: csr_wr_en writes csr_wr_data to register csr_index
// (0 mode, 1..3 gains p/i/d, 4 integral limit, 5 output limit); write only
// while no item is in flight.
// Throughput: one item per clock while rsp_stall is low. An item passes
// through six register stages before rsp_valid rises: error, product,
// saturate and sum, accumulate, output-sum and truncate.
// A stalled result holds in the output register; stages behind it keep
// filling any empty slots and req_stall rises only when every stage is full.
// Reset (synchronous) empties the pipeline, clears the error history and
// both accumulators, and loads the default gains and limits.

module pid_position_delta_controller_top #(
   parameter int FRAC_BITS  = 16,
   parameter int DATA_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [DATA_WIDTH-1:0]          req_measured,
   input  logic signed [DATA_WIDTH-1:0]          req_target,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [DATA_WIDTH-1:0]          rsp_drive,
   input  logic                                  csr_wr_en,
   input  logic [pdc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [pdc_pkg::CSR_DATA_WIDTH-1:0]    csr_wr_data
);
   import pdc_pkg::*;

   cfg_type                      cfg;
   logic                         opnd_valid, opnd_stall;
   logic signed [DATA_WIDTH+2:0] opnd_p, opnd_i, opnd_d;
   logic                         sum_valid, sum_stall;
   logic signed [SUM_WIDTH-1:0]  sum;
   logic signed [TERM_WIDTH-1:0] iterm;

   pdc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   pdc_error #(.DATA_WIDTH(DATA_WIDTH)) u_error (
      .clock        (clock),
      .reset        (reset),
      .loop_mode    (cfg.loop_mode),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_measured (req_measured),
      .req_target   (req_target),
      .opnd_valid   (opnd_valid),
      .opnd_stall   (opnd_stall),
      .opnd_p       (opnd_p),
      .opnd_i       (opnd_i),
      .opnd_d       (opnd_d)
   );

   pdc_term #(.DATA_WIDTH(DATA_WIDTH)) u_term (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .opnd_valid (opnd_valid),
      .opnd_stall (opnd_stall),
      .opnd_p     (opnd_p),
      .opnd_i     (opnd_i),
      .opnd_d     (opnd_d),
      .sum_valid  (sum_valid),
      .sum_stall  (sum_stall),
      .sum        (sum),
      .iterm      (iterm)
   );

   pdc_accum #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_accum (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .sum_valid (sum_valid),
      .sum_stall (sum_stall),
      .sum       (sum),
      .iterm     (iterm),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_drive (rsp_drive)
   );

endmodule

// ----- src/pdc_checker.sv -----
`timescale 1ns / 1ps

module pdc_checker #(
   parameter int DATA_WIDTH = 16
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [DATA_WIDTH-1:0]         rsp_drive
);
   localparam logic [DATA_WIDTH-1:0] DRIVE_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   // input backs up only when a finished result is held at the output
   a_stall_from_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled result");

   // no result reaches the output before passing every stage after reset
   a_reset_latency: assert property (@(posedge clock) disable iff (reset)
      $past(reset, 5) |-> !rsp_valid)
      else $error("result too soon after reset");

   // drive is symmetric and never takes the most negative code
   a_drive_symmetric: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive != DRIVE_MIN))
      else $error("drive outside symmetric range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_drive)))
      else $error("stalled result changed");

endmodule

bind pid_position_delta_controller_top pdc_checker #(.DATA_WIDTH(DATA_WIDTH)) u_checker (.*);
